@@ rtl/json_structure_writer_core_defines.svh @@
// assertion macros for the json structure writer rtl
// depends on clk and rst_n being visible in the module that uses them
`ifndef JSON_STRUCTURE_WRITER_CORE_DEFINES_SVH
`define JSON_STRUCTURE_WRITER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define JSW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define JSW_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define JSW_ASSERT(lbl, prop, msg)
`define JSW_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

@@ rtl/jsw_pkg.sv @@
// shared types, codes and helpers for the json structure writer
// no dependencies
package jsw_pkg;

  localparam logic [2:0] CMD_OBJ_OPEN  = 3'd0;
  localparam logic [2:0] CMD_OBJ_CLOSE = 3'd1;
  localparam logic [2:0] CMD_ARR_OPEN  = 3'd2;
  localparam logic [2:0] CMD_ARR_CLOSE = 3'd3;
  localparam logic [2:0] CMD_STR_OPEN  = 3'd4;
  localparam logic [2:0] CMD_STR_CHAR  = 3'd5;
  localparam logic [2:0] CMD_STR_CLOSE = 3'd6;

  localparam logic [1:0] KIND_BASE = 2'd0;
  localparam logic [1:0] KIND_PAIR = 2'd1;
  localparam logic [1:0] KIND_LIST = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVER  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;

  localparam logic [1:0] BODY_ONE = 2'd0;
  localparam logic [1:0] BODY_ESC = 2'd1;
  localparam logic [1:0] BODY_UNI = 2'd2;

  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_A         = 8'h61;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_NUL       = 8'h00;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic       sep_valid;
    logic [7:0] sep_byte;
    logic [1:0] body;
    logic [7:0] body_byte;
    logic [1:0] status;
  } desc_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) r = CH_ZERO + {4'd0, v};
    else r = CH_A + {4'd0, v} - 8'd10;
    return r;
  endfunction

  function automatic logic [2:0] body_len(input logic [1:0] body);
    logic [2:0] r;
    case (body)
      BODY_ESC: r = 3'd2;
      BODY_UNI: r = 3'd6;
      default:  r = 3'd1;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/jsw_queue.sv @@
// small descriptor queue between the front and back parts
// depends on jsw_pkg
module jsw_queue
  import jsw_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_data,
  output logic  full,
  input  logic  pop,
  output desc_t head,
  output logic  empty
);

  desc_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r;
  logic [QUEUE_AW-1:0]  rd_ptr_r;
  logic [QUEUE_CW-1:0]  count_r;
  logic [QUEUE_AW-1:0]  wr_ptr_nxt;
  logic [QUEUE_AW-1:0]  rd_ptr_nxt;
  logic [QUEUE_CW-1:0]  count_nxt;

  assign full  = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

@@ rtl/jsw_front.sv @@
// front part: accepts commands, tracks the context stack, classifies escapes
// depends on jsw_pkg; emits one descriptor per command 0 to 6 into the queue
module jsw_front
  import jsw_pkg::*;
#(
  parameter int MAX_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_cmd,
  input  logic [7:0] in_char_byte,
  input  logic       q_full,
  output logic       q_push,
  output desc_t      q_data
);

  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int DW = $clog2(MAX_DEPTH + 1);

  logic [3:0]    stack_mem [MAX_DEPTH];
  logic [3:0]    under_r;
  logic [1:0]    kind_r, kind_nxt;
  logic          first_r, first_nxt;
  logic          colon_r, colon_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [3:0]    wdata;
  logic          sep_v;
  logic [7:0]    sep_b;
  logic          first_sep, colon_sep;
  logic          fire;
  logic [7:0]    sc;

  assign in_ready = !q_full;
  assign fire     = in_valid && !q_full;
  assign waddr    = depth_r[AW-1:0];
  assign wdata    = {colon_sep, first_sep, kind_r};
  assign raddr    = (depth_nxt == '0) ? '0 : AW'(depth_nxt - 1'b1);

  // separator owed by the current context before a value
  always_comb begin
    sep_v     = 1'b0;
    sep_b     = CH_COMMA;
    first_sep = first_r;
    colon_sep = colon_r;
    case (kind_r)
      KIND_PAIR: begin
        if (first_r) begin
          first_sep = 1'b0;
          colon_sep = 1'b1;
        end else begin
          sep_v     = 1'b1;
          sep_b     = colon_r ? CH_COLON : CH_COMMA;
          colon_sep = !colon_r;
        end
      end
      KIND_LIST: begin
        if (first_r) first_sep = 1'b0;
        else sep_v = 1'b1;
      end
      default: ;
    endcase
  end

  // short escape code, zero when none
  always_comb begin
    case (in_char_byte)
      CH_QUOTE:     sc = CH_QUOTE;
      CH_BACKSLASH: sc = CH_BACKSLASH;
      8'h08:        sc = CH_B;
      8'h09:        sc = CH_T;
      8'h0A:        sc = CH_N;
      8'h0C:        sc = CH_F;
      8'h0D:        sc = CH_R;
      default:      sc = CH_NUL;
    endcase
  end

  always_comb begin
    kind_nxt  = kind_r;
    first_nxt = first_r;
    colon_nxt = colon_r;
    depth_nxt = depth_r;
    we        = 1'b0;
    q_push    = 1'b0;
    q_data    = '0;
    q_data.body   = BODY_ONE;
    q_data.status = ST_OK;
    if (fire) begin
      case (in_cmd)
        CMD_OBJ_OPEN, CMD_ARR_OPEN: begin
          q_push = 1'b1;
          if (depth_r == DW'(MAX_DEPTH)) begin
            q_data.status = ST_OVER;
          end else begin
            q_data.sep_valid = sep_v;
            q_data.sep_byte  = sep_b;
            q_data.body_byte = (in_cmd == CMD_OBJ_OPEN) ? CH_LBRACE : CH_LBRACKET;
            we        = 1'b1;
            kind_nxt  = (in_cmd == CMD_OBJ_OPEN) ? KIND_PAIR : KIND_LIST;
            first_nxt = 1'b1;
            colon_nxt = 1'b1;
            depth_nxt = depth_r + 1'b1;
          end
        end
        CMD_OBJ_CLOSE, CMD_ARR_CLOSE: begin
          q_push = 1'b1;
          if (depth_r == '0) begin
            q_data.status = ST_UNDER;
          end else begin
            q_data.body_byte = (in_cmd == CMD_OBJ_CLOSE) ? CH_RBRACE : CH_RBRACKET;
            depth_nxt = depth_r - 1'b1;
            kind_nxt  = under_r[1:0];
            first_nxt = under_r[2];
            colon_nxt = under_r[3];
          end
        end
        CMD_STR_OPEN: begin
          q_push           = 1'b1;
          q_data.sep_valid = sep_v;
          q_data.sep_byte  = sep_b;
          q_data.body_byte = CH_QUOTE;
          first_nxt        = first_sep;
          colon_nxt        = colon_sep;
        end
        CMD_STR_CHAR: begin
          q_push = 1'b1;
          if (sc != CH_NUL) begin
            q_data.body      = BODY_ESC;
            q_data.body_byte = sc;
          end else if (in_char_byte < CH_SPACE) begin
            q_data.body      = BODY_UNI;
            q_data.body_byte = in_char_byte;
          end else begin
            q_data.body_byte = in_char_byte;
          end
        end
        CMD_STR_CLOSE: begin
          q_push           = 1'b1;
          q_data.body_byte = CH_QUOTE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= KIND_BASE;
      first_r <= 1'b1;
      colon_r <= 1'b1;
      depth_r <= '0;
    end else begin
      kind_r  <= kind_nxt;
      first_r <= first_nxt;
      colon_r <= colon_nxt;
      depth_r <= depth_nxt;
    end
  end

  // saved contexts; under_r always holds the entry below the current one
  always_ff @(posedge clk) begin
    if (we) stack_mem[waddr] <= wdata;
    under_r <= (we && waddr == raddr) ? wdata : stack_mem[raddr];
  end

endmodule

@@ rtl/jsw_back.sv @@
// back part: expands queued descriptors into text bytes behind an output register
// depends on jsw_pkg and the assertion macro header
`include "json_structure_writer_core_defines.svh"
module jsw_back
  import jsw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  desc_t      head,
  input  logic       empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic [1:0] out_status
);

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic [1:0] out_status_r;
  logic       sep_done_r;
  logic [2:0] bi_r;
  logic       sep_phase;
  logic       body_last;
  logic       load;
  logic [7:0] body_b;
  logic [7:0] cur_byte;

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

  assign sep_phase = head.sep_valid && !sep_done_r;
  assign body_last = (bi_r == body_len(head.body) - 3'd1);
  assign load      = !empty && (!out_valid_r || out_ready);
  assign pop       = load && !sep_phase && body_last;

  always_comb begin
    body_b = head.body_byte;
    case (head.body)
      BODY_ESC: body_b = (bi_r == 3'd0) ? CH_BACKSLASH : head.body_byte;
      BODY_UNI: begin
        case (bi_r)
          3'd0:    body_b = CH_BACKSLASH;
          3'd1:    body_b = CH_U;
          3'd2:    body_b = CH_ZERO;
          3'd3:    body_b = CH_ZERO;
          3'd4:    body_b = hex_digit(head.body_byte[7:4]);
          default: body_b = hex_digit(head.body_byte[3:0]);
        endcase
      end
      default: ;
    endcase
    cur_byte = sep_phase ? head.sep_byte : body_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sep_done_r  <= 1'b0;
      bi_r        <= '0;
    end else begin
      if (!out_valid_r || out_ready) out_valid_r <= !empty;
      if (load) begin
        if (pop) begin
          sep_done_r <= 1'b0;
          bi_r       <= '0;
        end else if (sep_phase) begin
          sep_done_r <= 1'b1;
        end else begin
          bi_r <= bi_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r   <= cur_byte;
      out_last_r   <= !sep_phase && body_last;
      out_status_r <= head.status;
    end
  end

  `JSW_ASSERT(a_err_single, out_valid_r && out_status_r != ST_OK |-> out_last_r && out_byte_r == CH_NUL, "error result must be a lone zero byte")
  `JSW_ASSERT(a_step_in_range, !empty |-> bi_r < body_len(head.body), "body step beyond descriptor length")
  `JSW_ASSERT_NEVER(a_sep_skipped, bi_r != 3'd0 && head.sep_valid && !sep_done_r, "body started before separator")
  `JSW_ASSERT(a_idle_step_clear, empty |-> bi_r == 3'd0 && !sep_done_r, "step state left over with empty queue")

endmodule

@@ rtl/json_structure_writer_core.sv @@
// JSON structure writer core: structure commands in, JSON text bytes out.
// Input channel in_valid/in_ready carries in_cmd (0 object open, 1 object close,
// 2 array open, 3 array close, 4 string open, 5 string byte, 6 string close) and
// in_char_byte. Output channel out_valid/out_ready carries out_byte, out_last
// (final byte of one command) and out_status (0 ok, 1 overflow, 2 underflow).
// A command is accepted whenever the four-entry descriptor queue has room; the
// front part updates the context stack in the accepting cycle, so commands
// follow back to back. The back part sends one byte per cycle while the
// receiver is ready; a command yields 1 to 6 bytes (separator plus bracket, or
// six bytes for a \u00XX escape), queued and then held in the output register.
// Sustained rate is one command per cycle if each yields one byte and is taken.
// Command 7 is accepted and yields nothing. A stalled receiver holds the output
// register; the queue then fills and in_ready drops until bytes drain.
// Synchronous reset empties the queue and output register and returns to the
// base context with an empty stack; the saved context memory is not cleared.
// depends on jsw_pkg, jsw_front, jsw_queue, jsw_back
module json_structure_writer_core
  import jsw_pkg::*;
#(
  parameter int MAX_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_cmd,
  input  logic [7:0] in_char_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic [1:0] out_status
);

  logic  q_push;
  desc_t q_data;
  logic  q_full;
  logic  q_pop;
  desc_t q_head;
  logic  q_empty;

  jsw_front #(.MAX_DEPTH(MAX_DEPTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_char_byte (in_char_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_data)
  );

  jsw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  jsw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .out_status (out_status)
  );

endmodule
